/* design/psk_pkg.sv */
// Package for the Knuth Poisson sampler: sequencer states, control and status
// bundles, generator constants and register indexes. No dependencies.
package psk_pkg;

   // Generator multiplier 0x5DEECE66D split into 24-bit halves, and its increment.
   localparam int           HALF_BITS      = 24;
   localparam logic [23:0]  LCG_MUL_LO     = 24'hECE66D;
   localparam logic [23:0]  LCG_MUL_HI     = 24'h0005DE;
   localparam logic [47:0]  LCG_ADD        = 48'h00000000000B;

   // Register reset values.
   localparam logic [31:0]  THRESHOLD_RESET = 32'd1580030169;
   localparam logic [47:0]  SEED_RESET      = 48'd20017429951246;

   // Configuration register indexes.
   localparam logic         CSR_THRESHOLD  = 1'b0;
   localparam logic         CSR_SEED       = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LCG_LL,
      ST_LCG_HL,
      ST_LCG_LH,
      ST_LCG_SUM,
      ST_PROD_MUL,
      ST_PROD_ACC,
      ST_TEST
   } state_type;

   // Operand pairs for the shared multiplier.
   typedef enum logic [1:0] {
      MUL_XL_ML,
      MUL_XH_ML,
      MUL_XL_MH,
      MUL_PROD_U
   } mul_op_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic       idle;
      mul_op_type mul_op;
      logic       acc_load;
      logic       acc_add;
      logic       gen_step;
      logic       prod_from_uniform;
      logic       prod_from_mul;
      logic       count_inc;
      logic       sat_set;
      logic       rsp_load;
   } ctrl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic req_draw;
      logic first;
      logic prod_above;
      logic count_full;
      logic rsp_free;
   } status_type;

endpackage

/* design/psk_mul.sv */
// Shared 32 x 32 multiplier with a registered product.
// Used for the generator partial products and the running product.
module psk_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);

   logic [63:0] product_ff;
   logic [63:0] product_in;

   // One product per cycle, registered before any use.
   assign product_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

/* design/psk_seq.sv */
// Sequencer for the Poisson sampler: steps the generator and the product loop.
// Depends on psk_pkg for the state, control and status types.
module psk_seq (
   input  logic                clock,
   input  logic                reset,
   input  psk_pkg::status_type status,
   output psk_pkg::ctrl_type   ctrl
);

   psk_pkg::state_type state_ff;
   psk_pkg::state_type state_in;
   logic               done_ff;
   logic               done_in;

   // Pending result waiting for a free output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psk_pkg::ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      case (state_ff)
         psk_pkg::ST_IDLE: begin
            if (done_ff) begin
               if (status.rsp_free) begin
                  done_in = 1'b0;
               end
            end else if (status.req_draw) begin
               state_in = psk_pkg::ST_LCG_LL;
            end
         end
         psk_pkg::ST_LCG_LL:  state_in = psk_pkg::ST_LCG_HL;
         psk_pkg::ST_LCG_HL:  state_in = psk_pkg::ST_LCG_LH;
         psk_pkg::ST_LCG_LH:  state_in = psk_pkg::ST_LCG_SUM;
         psk_pkg::ST_LCG_SUM: state_in = psk_pkg::ST_PROD_MUL;
         psk_pkg::ST_PROD_MUL: begin
            state_in = status.first ? psk_pkg::ST_TEST : psk_pkg::ST_PROD_ACC;
         end
         psk_pkg::ST_PROD_ACC: state_in = psk_pkg::ST_TEST;
         psk_pkg::ST_TEST: begin
            if (status.prod_above && !status.count_full) begin
               state_in = psk_pkg::ST_LCG_LL;
            end else begin
               state_in = psk_pkg::ST_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = psk_pkg::ST_IDLE;
            done_in  = 1'b0;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl                   = '0;
      ctrl.mul_op            = psk_pkg::MUL_XL_ML;
      case (state_ff)
         psk_pkg::ST_IDLE: begin
            ctrl.idle     = !done_ff;
            ctrl.rsp_load = done_ff && status.rsp_free;
         end
         psk_pkg::ST_LCG_LL: ctrl.mul_op = psk_pkg::MUL_XL_ML;
         psk_pkg::ST_LCG_HL: begin
            ctrl.mul_op   = psk_pkg::MUL_XH_ML;
            ctrl.acc_load = 1'b1;
         end
         psk_pkg::ST_LCG_LH: begin
            ctrl.mul_op  = psk_pkg::MUL_XL_MH;
            ctrl.acc_add = 1'b1;
         end
         psk_pkg::ST_LCG_SUM: ctrl.gen_step = 1'b1;
         psk_pkg::ST_PROD_MUL: begin
            ctrl.mul_op            = psk_pkg::MUL_PROD_U;
            ctrl.prod_from_uniform = status.first;
         end
         psk_pkg::ST_PROD_ACC: ctrl.prod_from_mul = 1'b1;
         psk_pkg::ST_TEST: begin
            ctrl.count_inc = status.prod_above && !status.count_full;
            ctrl.sat_set   = status.prod_above && status.count_full;
         end
         default: ctrl.idle = 1'b0;
      endcase
   end

endmodule

/* design/poisson_sampler_knuth.sv */
// Top level of the Knuth Poisson sampler: registers, generator and product datapath.
// Depends on psk_pkg, psk_mul (shared multiplier) and psk_seq (sequencer).
//
//   Channel | Ports                               | Direction
//   req     | req_valid, req_stall, req_reseed    | in, beat per item
//   rsp     | rsp_valid, rsp_stall, rsp_sample,   | out, one beat per draw
//           | rsp_saturated                       |
//   csr     | csr_write, csr_index, csr_data      | in, write only
//
// A reseed beat gives no result. A draw shows its result in the output register, and
// the next beat is taken only after that result is loaded: every uniform costs three
// 24 x 24 partial products and a sum on the one shared multiplier, and each further
// uniform one more product and its load.
// Synchronous reset loads the register reset values and seeds the generator.
// A result that waits under rsp_stall holds the sequencer after it finishes the next draw.
module poisson_sampler_knuth #(
   parameter int MAX_COUNT    = 255,
   parameter int UNIFORM_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_reseed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sample,
   output logic        rsp_saturated,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [47:0] csr_data
);

   localparam int          CW         = $clog2(MAX_COUNT + 1);
   localparam int          ZERO_BITS  = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
   localparam logic [31:0] UNI_MASK   = 32'hFFFFFFFF << ZERO_BITS;
   localparam logic [7:0]  SAT_SAMPLE = (MAX_COUNT > 255) ? 8'd255 : 8'(MAX_COUNT);

   psk_pkg::ctrl_type   ctrl;
   psk_pkg::status_type status;

   logic [31:0] threshold_ff, threshold_in;
   logic [47:0] seed_ff, seed_in;
   logic [47:0] gen_ff, gen_in;
   logic [47:0] acc_ff, acc_in;
   logic [31:0] prod_ff, prod_in;
   logic [CW-1:0] count_ff, count_in;
   logic        sat_ff, sat_in;
   logic        first_ff, first_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_sample_ff, rsp_sample_in;
   logic        rsp_sat_ff, rsp_sat_in;

   logic        req_accept;
   logic [31:0] uniform;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [47:0] mul_shifted;
   logic [15:0] count_wide;

   assign req_accept = req_valid && ctrl.idle;
   assign req_stall  = !ctrl.idle;

   // Uniform from the top bits of the generator, aligned to Q0.32.
   assign uniform = gen_ff[47:16] & UNI_MASK;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.mul_op)
         psk_pkg::MUL_XL_ML: begin
            mul_a = 32'(gen_ff[23:0]);
            mul_b = 32'(psk_pkg::LCG_MUL_LO);
         end
         psk_pkg::MUL_XH_ML: begin
            mul_a = 32'(gen_ff[47:24]);
            mul_b = 32'(psk_pkg::LCG_MUL_LO);
         end
         psk_pkg::MUL_XL_MH: begin
            mul_a = 32'(gen_ff[23:0]);
            mul_b = 32'(psk_pkg::LCG_MUL_HI);
         end
         psk_pkg::MUL_PROD_U: begin
            mul_a = prod_ff;
            mul_b = uniform;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   psk_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   psk_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Cross partial products only reach the upper half of the 48-bit state.
   assign mul_shifted = {mul_p[psk_pkg::HALF_BITS-1:0], 24'd0};

   assign status.req_draw   = req_accept && !req_reseed;
   assign status.first      = first_ff;
   assign status.prod_above = prod_ff > threshold_ff;
   assign status.count_full = count_ff >= CW'(MAX_COUNT);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Configuration writes.
   always_comb begin
      threshold_in = threshold_ff;
      seed_in      = seed_ff;
      if (csr_write) begin
         case (csr_index)
            psk_pkg::CSR_THRESHOLD: threshold_in = csr_data[31:0];
            psk_pkg::CSR_SEED:      seed_in      = csr_data;
            default:                threshold_in = threshold_ff;
         endcase
      end
   end

   // Generator, accumulator and product loop.
   always_comb begin
      gen_in   = gen_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      first_in = first_ff;
      if (req_accept && req_reseed) begin
         gen_in = seed_ff;
      end
      if (status.req_draw) begin
         count_in = '0;
         sat_in   = 1'b0;
         first_in = 1'b1;
      end
      if (ctrl.acc_load) begin
         acc_in = mul_p[47:0];
      end
      if (ctrl.acc_add) begin
         acc_in = acc_ff + mul_shifted;
      end
      if (ctrl.gen_step) begin
         gen_in = acc_ff + mul_shifted + psk_pkg::LCG_ADD;
      end
      if (ctrl.prod_from_uniform) begin
         prod_in  = uniform;
         first_in = 1'b0;
      end
      if (ctrl.prod_from_mul) begin
         prod_in = mul_p[63:32];
      end
      if (ctrl.count_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (ctrl.sat_set) begin
         sat_in = 1'b1;
      end
   end

   // Output register; counts above eight bits report as 255.
   assign count_wide = 16'(count_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = (count_wide > 16'd255) ? 8'd255 : count_wide[7:0];
         rsp_sat_in    = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= psk_pkg::THRESHOLD_RESET;
         seed_ff      <= psk_pkg::SEED_RESET;
         gen_ff       <= psk_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      count_ff      <= count_in;
      sat_ff        <= sat_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   // A saturated result always reports the count limit.
   a_sat_sample : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_sample == SAT_SAMPLE)
      else $error("saturated result with a count below the limit");

   // The count never runs past the limit.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      !first_ff && !ctrl.idle |-> count_ff <= CW'(MAX_COUNT))
      else $error("draw count beyond the limit");

   // The generator moves only on a generator step or a reseed beat.
   a_gen_moves : assert property (@(posedge clock) disable iff (reset)
      !$stable(gen_ff) |-> $past(reset) || $past(ctrl.gen_step)
                           || $past(req_accept && req_reseed))
      else $error("generator state changed outside a step or reseed");
`endif

endmodule
